>>> hdl/byte_stuffed_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver RTL.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication.
`define BSFR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bsfr_pkg.sv
// Package for the byte-stuffed frame receiver: phase and status codes,
// register indexes, reset values and the result word type. No dependencies.
package bsfr_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLAG      = 3'd0,
    REG_ESCAPE    = 3'd1,
    REG_ESC_FLAG  = 3'd2,
    REG_INFO_EVEN = 3'd3,
    REG_INFO_ODD  = 3'd4
  } reg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [7:0] FLAG_RST      = 8'h7e;
  localparam logic [7:0] ESCAPE_RST    = 8'h7d;
  localparam logic [7:0] ESC_FLAG_RST  = 8'h5e;
  localparam logic [7:0] INFO_EVEN_RST = 8'h00;
  localparam logic [7:0] INFO_ODD_RST  = 8'h40;

  // Receive phases.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_CTRL = 3'd2,
    PH_HCHK = 3'd3,
    PH_DATA = 3'd4,
    PH_SEND = 3'd5
  } phase_t;

  // Frame-end status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_HDR_BAD   = 2'd1,
    ST_DATA_BAD  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  // Result kinds.
  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  // One result word.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    status_t    status;
    logic [7:0] address;
    logic [7:0] control;
    logic       is_info;
  } result_t;

endpackage

>>> hdl/bsfr_if.sv
// Handshake channels of the frame receiver: received bytes, results and
// configuration writes. Uses bsfr_pkg for the index width.
interface bsfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bsfr_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic [7:0] frame_address;
  logic [7:0] frame_control;
  logic       is_information;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_status, output frame_address, output frame_control,
                  output is_information, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input frame_status, input frame_address, input frame_control,
                input is_information, output ready);
endinterface

interface bsfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bsfr_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                     wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> hdl/byte_stuffed_frame_receiver.sv
// Result words are registered: the result channel is driven from the output word of the result buffer.
// Throughput: one byte per cycle while the skid word is free; each byte updates the receive state in a single pass.
// A two-word result buffer lets bytes keep arriving while a result waits for the sink.
// Reset (synchronous, active high) restores the default configuration, clears the
// frame state to flag hunting and empties the result buffer.
`include "byte_stuffed_frame_receiver_defines.svh"

module byte_stuffed_frame_receiver
  import bsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bsfr_rx_if.sink     rx,
  bsfr_res_if.source  res,
  bsfr_cfg_if.sink    cfg
);

  // Configuration registers.
  logic [7:0] flag_byte;
  logic [7:0] escape_byte;
  logic [7:0] escaped_flag_code;
  logic [7:0] info_control_even;
  logic [7:0] info_control_odd;

  // Frame state.
  phase_t     phase, phase_next;
  logic [7:0] address_reg, address_reg_next;
  logic [7:0] control_reg, control_reg_next;
  logic [7:0] header_check, header_check_next;
  logic       escape_pending, escape_pending_next;
  logic       held_valid, held_valid_next;
  logic [7:0] held_byte, held_byte_next;
  logic [7:0] running_xor, running_xor_next;

  // Result buffer: output word and skid word.
  logic    o_valid;
  result_t o_data;
  logic    s_valid;
  result_t s_data;

  logic    in_fire;
  logic    pop;
  logic    push;
  result_t r;
  logic    is_info;
  logic    hdr_ok;
  logic    is_flag;
  logic [7:0] b;
  logic [7:0] destuffed;

  assign b       = rx.rx_byte;
  assign rx.ready = !s_valid;
  assign in_fire = rx.valid && rx.ready;
  assign pop     = o_valid && res.ready;
  assign is_info = (control_reg == info_control_even) || (control_reg == info_control_odd);
  assign hdr_ok  = (address_reg ^ control_reg) == header_check;
  assign is_flag = b == flag_byte;

  // Configuration writes; indexes past the list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte         <= FLAG_RST;
      escape_byte       <= ESCAPE_RST;
      escaped_flag_code <= ESC_FLAG_RST;
      info_control_even <= INFO_EVEN_RST;
      info_control_odd  <= INFO_ODD_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_FLAG:      flag_byte         <= cfg.wdata;
        REG_ESCAPE:    escape_byte       <= cfg.wdata;
        REG_ESC_FLAG:  escaped_flag_code <= cfg.wdata;
        REG_INFO_EVEN: info_control_even <= cfg.wdata;
        REG_INFO_ODD:  info_control_odd  <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      unique case (phase)
        PH_ADDR: phase_next = PH_CTRL;
        PH_CTRL: phase_next = PH_HCHK;
        PH_HCHK: phase_next = is_info ? PH_DATA : PH_SEND;
        PH_DATA: phase_next = is_flag ? PH_HUNT : PH_DATA;
        PH_SEND: phase_next = is_flag ? PH_HUNT : PH_SEND;
        default: phase_next = is_flag ? PH_ADDR : PH_HUNT;
      endcase
    end
  end

  // Escape decode of a data byte.
  assign destuffed = escape_pending ?
                     ((b == escaped_flag_code) ? flag_byte : escape_byte) : b;

  // Result and datapath updates for the accepted byte.
  always_comb begin
    address_reg_next    = address_reg;
    control_reg_next    = control_reg;
    header_check_next   = header_check;
    escape_pending_next = escape_pending;
    held_valid_next     = held_valid;
    held_byte_next      = held_byte;
    running_xor_next    = running_xor;
    push                = 1'b0;
    r.kind              = KIND_DATA;
    r.payload           = 8'h00;
    r.status            = ST_OK;
    r.address           = address_reg;
    r.control           = control_reg;
    r.is_info           = is_info;
    if (in_fire) begin
      unique case (phase)
        PH_ADDR: address_reg_next = b;
        PH_CTRL: control_reg_next = b;
        PH_HCHK: begin
          header_check_next   = b;
          escape_pending_next = 1'b0;
          held_valid_next     = 1'b0;
          held_byte_next      = 8'h00;
          running_xor_next    = 8'h00;
        end
        PH_DATA: begin
          if (is_flag) begin
            push   = 1'b1;
            r.kind = KIND_END;
            priority if (escape_pending || !held_valid) r.status = ST_MALFORMED;
            else if (!hdr_ok)                        r.status = ST_HDR_BAD;
            else if (held_byte != running_xor)       r.status = ST_DATA_BAD;
            else                                     r.status = ST_OK;
            escape_pending_next = 1'b0;
            held_valid_next     = 1'b0;
          end else if (!escape_pending && (b == escape_byte)) begin
            escape_pending_next = 1'b1;
          end else begin
            // A destuffed byte replaces the held one, which goes out now.
            escape_pending_next = 1'b0;
            if (held_valid) begin
              push             = 1'b1;
              r.payload        = held_byte;
              running_xor_next = running_xor ^ held_byte;
            end
            held_byte_next  = destuffed;
            held_valid_next = 1'b1;
          end
        end
        PH_SEND: begin
          if (is_flag) begin
            push     = 1'b1;
            r.kind   = KIND_END;
            r.status = hdr_ok ? ST_OK : ST_HDR_BAD;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      address_reg    <= 8'h00;
      control_reg    <= 8'h00;
      header_check   <= 8'h00;
      escape_pending <= 1'b0;
      held_valid     <= 1'b0;
      held_byte      <= 8'h00;
      running_xor    <= 8'h00;
    end else begin
      phase          <= phase_next;
      address_reg    <= address_reg_next;
      control_reg    <= control_reg_next;
      header_check   <= header_check_next;
      escape_pending <= escape_pending_next;
      held_valid     <= held_valid_next;
      held_byte      <= held_byte_next;
      running_xor    <= running_xor_next;
    end
  end

  // Two-word result buffer; a new word enters only when the skid word is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || pop) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= push;
      end
    end else if (push) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || pop) begin
      o_data <= s_valid ? s_data : r;
    end else if (push) begin
      s_data <= r;
    end
  end

  // Result channel outputs.
  assign res.valid          = o_valid;
  assign res.result_kind    = o_data.kind;
  assign res.payload_byte   = o_data.payload;
  assign res.frame_status   = o_data.status;
  assign res.frame_address  = o_data.address;
  assign res.frame_control  = o_data.control;
  assign res.is_information = o_data.is_info;

  // Assertions.
  `BSFR_ASSERT(a_skid_needs_out, s_valid, o_valid, "skid word held with empty output word")
  `BSFR_ASSERT(a_data_only_in_field, push && (r.kind == KIND_DATA), phase == PH_DATA,
    "data byte produced outside the data field")
  `BSFR_ASSERT(a_escape_in_field, escape_pending, phase == PH_DATA,
    "escape pending outside the data field")
  `BSFR_ASSERT_NEXT(a_end_to_hunt, push && (r.kind == KIND_END), phase == PH_HUNT,
    "frame end did not return to flag hunting")

endmodule
